// ===== rtl/rn48_pkg.sv =====
// Shared types and constants for the 48-way radix node child table.
// Holds operation and status codes and the request/result transfer structs.
// No dependencies.
package rn48_pkg;

  localparam int KEY_SPACE     = 256;
  localparam int KEY_W         = 8;
  localparam int FIELD_PTR_W   = 64;
  localparam int COUNT_W       = 6;
  localparam int DEF_SLOTS     = 48;
  localparam int DEF_PTR_WIDTH = 64;

  localparam logic [KEY_W-1:0] EMPTY_MARK = 8'hFF;

  typedef enum logic [1:0] {
    OP_LOOKUP  = 2'd0,
    OP_INSERT  = 2'd1,
    OP_REPLACE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]             operation;
    logic [KEY_W-1:0]       key_sel;
    logic [FIELD_PTR_W-1:0] child_value;
  } req_t;

  typedef struct packed {
    logic [FIELD_PTR_W-1:0] found_child;
    logic [1:0]             status;
    logic [COUNT_W-1:0]     child_count;
  } rsp_t;

endpackage

// ===== rtl/rn48_index_mem.sv =====
// Key-byte index: 256 x 8 synchronous memory, one read and one write port.
// Per-entry valid flags give the empty marker for entries not yet written.
// Depends on rn48_pkg.
module rn48_index_mem
  import rn48_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [KEY_W-1:0] rd_addr,
  output logic [KEY_W-1:0] rd_data,
  input  logic             wr_en,
  input  logic [KEY_W-1:0] wr_addr,
  input  logic [KEY_W-1:0] wr_data
);

  logic [KEY_W-1:0]     mem [KEY_SPACE];
  logic [KEY_SPACE-1:0] vld;
  logic [KEY_W-1:0]     mem_q;
  logic                 vld_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_q <= vld[rd_addr];
      end
    end
  end

  assign rd_data = vld_q ? mem_q : EMPTY_MARK;

endmodule

// ===== rtl/rn48_slot_mem.sv =====
// Child slot store: SLOTS x PTR_WIDTH synchronous memory with occupancy flags.
// A flag is set while its slot holds a non-zero child; the lowest clear flag
// names the free slot. Depends on rn48_pkg.
module rn48_slot_mem
  import rn48_pkg::*;
#(
  parameter int SLOTS     = DEF_SLOTS,
  parameter int PTR_WIDTH = DEF_PTR_WIDTH,
  parameter int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic [SLOT_W-1:0]    rd_addr,
  output logic [PTR_WIDTH-1:0] rd_data,
  input  logic                 wr_en,
  input  logic [SLOT_W-1:0]    wr_addr,
  input  logic [PTR_WIDTH-1:0] wr_data,
  output logic [SLOT_W-1:0]    free_slot,
  output logic                 free_found
);

  logic [PTR_WIDTH-1:0] mem [SLOTS];
  logic [SLOTS-1:0]     occ;
  logic [PTR_WIDTH-1:0] mem_q;
  logic                 occ_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ   <= '0;
      occ_q <= 1'b0;
    end else begin
      if (wr_en) begin
        occ[wr_addr] <= (wr_data != '0);
      end
      if (rd_en) begin
        occ_q <= occ[rd_addr];
      end
    end
  end

  // a slot never written or last written with zero reads as zero
  assign rd_data = occ_q ? mem_q : '0;

  // lowest slot holding zero
  always_comb begin
    free_slot  = '0;
    free_found = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!occ[i]) begin
        free_slot  = SLOT_W'(i);
        free_found = 1'b1;
      end
    end
  end

endmodule

// ===== rtl/radix_node48_child_table.sv =====
// Top level of the 48-way radix node child table: control and result register.
// Instantiates rn48_index_mem and rn48_slot_mem; depends on rn48_pkg.
//
//   port group        dir  timing
//   start/busy/request in  transfer when start is high and busy is low
//   done/result        out one-cycle strobe, cannot be held off
//
// In an operation the accept cycle reads the key-byte index,
// the busy cycle resolves the slot and reads or writes the slot memory, and
// the result strobes in the following cycle while the next request may
// already be accepted. Reset clears both stores at once through valid and
// occupancy flags, so no clearing pass is needed. The receiver cannot stall;
// busy is high for exactly one cycle after each transfer.
module radix_node48_child_table
  import rn48_pkg::*;
#(
  parameter int SLOTS     = DEF_SLOTS,
  parameter int PTR_WIDTH = DEF_PTR_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic done,
  output rsp_t result
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);

  logic accept;
  req_t req_q;

  logic [KEY_W-1:0]     idx_rdata;
  logic                 idx_wr_en;
  logic                 present;
  logic                 is_lookup, is_insert, is_replace;
  logic                 insert_ok;
  logic                 slot_rd_en, slot_wr_en;
  logic [SLOT_W-1:0]    slot_wr_addr;
  logic [PTR_WIDTH-1:0] slot_rdata;
  logic [SLOT_W-1:0]    free_slot;
  logic                 free_found;

  logic [CNT_W-1:0] used, used_next;
  logic [1:0]       status_next;
  logic [1:0]       status_q;
  logic [CNT_W-1:0] count_q;
  logic             hit_q;

  assign accept = start && !busy;

  // hold the request for the resolve cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= request;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      used <= '0;
    end else begin
      busy <= accept;
      done <= busy;
      used <= used_next;
    end
  end

  rn48_index_mem u_index (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (request.key_sel),
    .rd_data (idx_rdata),
    .wr_en   (idx_wr_en),
    .wr_addr (req_q.key_sel),
    .wr_data (KEY_W'(free_slot))
  );

  // an index entry beyond the slot range counts as absent
  assign present    = (idx_rdata != EMPTY_MARK) && (idx_rdata < KEY_W'(SLOTS));
  assign is_lookup  = busy && (req_q.operation == OP_LOOKUP);
  assign is_insert  = busy && (req_q.operation == OP_INSERT);
  assign is_replace = busy && (req_q.operation == OP_REPLACE);

  // insert needs room in the count and a slot that holds zero
  assign insert_ok    = is_insert && (used < CNT_W'(SLOTS)) && free_found;
  assign idx_wr_en    = insert_ok;
  assign slot_rd_en   = is_lookup && present;
  assign slot_wr_en   = insert_ok || (is_replace && present);
  assign slot_wr_addr = insert_ok ? free_slot : idx_rdata[SLOT_W-1:0];

  rn48_slot_mem #(
    .SLOTS     (SLOTS),
    .PTR_WIDTH (PTR_WIDTH),
    .SLOT_W    (SLOT_W)
  ) u_slots (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (slot_rd_en),
    .rd_addr    (idx_rdata[SLOT_W-1:0]),
    .rd_data    (slot_rdata),
    .wr_en      (slot_wr_en),
    .wr_addr    (slot_wr_addr),
    .wr_data    (req_q.child_value[PTR_WIDTH-1:0]),
    .free_slot  (free_slot),
    .free_found (free_found)
  );

  always_comb begin
    used_next   = used;
    status_next = ST_OK;
    if (insert_ok) begin
      used_next = used + CNT_W'(1);
    end
    if (is_insert && !insert_ok) begin
      status_next = ST_FULL;
    end
    if ((is_lookup || is_replace) && !present) begin
      status_next = ST_ABSENT;
    end
  end

  // capture the result; the looked-up child arrives from the slot memory
  always_ff @(posedge clk) begin
    if (busy) begin
      status_q <= status_next;
      count_q  <= used_next;
      hit_q    <= is_lookup && present;
    end
  end

  always_comb begin
    result             = '0;
    result.found_child = hit_q ? FIELD_PTR_W'(slot_rdata) : '0;
    result.status      = status_q;
    result.child_count = COUNT_W'(count_q);
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(SLOTS))
    else $error("child count above slot total");

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held for more than one cycle");

  a_count_reported: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.child_count == COUNT_W'(used)))
    else $error("reported child count differs from stored count");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (slot_wr_en || idx_wr_en) |-> busy)
    else $error("store written outside the resolve cycle");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for radix_node48_child_table: directed requests, then random ones.
// Shadows the index and slot stores; checks each strobe against them or a hand-typed result.
// Depends on rn48_pkg and the RTL of the node table.
module tb;
  import rn48_pkg::*;

  // The operation field is two bits wide; the spare code must be ignored by the node.
  localparam logic [1:0] OP_IGNORED   = 2'd3;
  localparam int         RANDOM_ITEMS = 1030;
  localparam int         QUIET_FIRST  = 400;   // random items in this span see no idling
  localparam int         QUIET_LAST   = 600;
  localparam int         MAX_REPORTS  = 10;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic done;
  req_t request;
  rsp_t result;

  radix_node48_child_table u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  // Shadow of the node: key byte -> slot index, slot -> child pointer, child total.
  logic [KEY_W-1:0]         key_slot [KEY_SPACE];
  logic [DEF_PTR_WIDTH-1:0] slot_ptr [DEF_SLOTS];
  int unsigned              child_total;

  rsp_t             pending_rsp [$];   // results owed by the node, oldest first
  logic [KEY_W-1:0] known_keys  [$];   // key bytes that were inserted successfully

  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned full_seen;
  int unsigned absent_seen;
  int unsigned requests_sent;

  typedef struct {
    req_t req;
    bit   typed;   // expected result written out by hand in the row
    rsp_t want;
  } dir_row_t;

  dir_row_t dir_rows [$];

  // Free-running clock, period 4.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the node stops answering.
  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

  // Apply one request to the shadow node and return the result it must give.
  function automatic rsp_t node_apply(req_t r);
    rsp_t             o;
    logic [KEY_W-1:0] s;
    bit               hit;
    int               free_pos;
    int               i;
    o   = '0;
    s   = key_slot[r.key_sel];
    // An index entry outside the slot range reads as absent.
    hit = (s != EMPTY_MARK) && (s < DEF_SLOTS);
    case (r.operation)
      OP_LOOKUP: begin
        if (hit) o.found_child = slot_ptr[s];
        else     o.status      = ST_ABSENT;
      end
      OP_INSERT: begin
        if (child_total >= DEF_SLOTS) begin
          o.status = ST_FULL;
        end else begin
          // Lowest slot holding zero; a stored zero child still looks free.
          free_pos = -1;
          for (i = DEF_SLOTS - 1; i >= 0; i--)
            if (slot_ptr[i] == '0) free_pos = i;
          if (free_pos < 0) begin
            o.status = ST_FULL;
          end else begin
            // A key already present is simply re-pointed; its old slot keeps its child.
            key_slot[r.key_sel] = free_pos[KEY_W-1:0];
            slot_ptr[free_pos]  = r.child_value;
            child_total++;
          end
        end
      end
      OP_REPLACE: begin
        if (hit) slot_ptr[s] = r.child_value;
        else     o.status    = ST_ABSENT;
      end
      default: ;  // spare code: no change, plain OK
    endcase
    o.child_count = child_total[COUNT_W-1:0];
    return o;
  endfunction

  function automatic dir_row_t row(logic [1:0] op, logic [KEY_W-1:0] key,
                                   logic [FIELD_PTR_W-1:0] child, bit typed,
                                   logic [FIELD_PTR_W-1:0] found, logic [1:0] st,
                                   logic [COUNT_W-1:0] cnt);
    dir_row_t d;
    d.req.operation    = op;
    d.req.key_sel      = key;
    d.req.child_value  = child;
    d.typed            = typed;
    d.want.found_child = found;
    d.want.status      = st;
    d.want.child_count = cnt;
    return d;
  endfunction

  // Offer one request, optionally after random idle cycles, and hold it until transfer.
  task automatic issue(req_t r, bit typed, rsp_t want, bit may_idle);
    rsp_t predicted;
    while (may_idle && $urandom_range(99) < 23) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    // Transfer happened at this edge: advance the shadow and queue the result.
    predicted = node_apply(r);
    pending_rsp.push_back(typed ? want : predicted);
    requests_sent++;
    if (r.operation == OP_INSERT && predicted.status == ST_OK)
      known_keys.push_back(r.key_sel);
  endtask

  // Result checker: each strobe must match the oldest outstanding expectation.
  always @(posedge clk) begin : result_check
    rsp_t want;
    bit   bad;
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] unexpected result: found=%h status=%0d count=%0d", $time,
                   result.found_child, result.status, result.child_count);
      end else begin
        want = pending_rsp.pop_front();
        results_seen++;
        if (result.status == ST_FULL)   full_seen++;
        if (result.status == ST_ABSENT) absent_seen++;
        bad = (result.found_child !== want.found_child) ||
              (result.status      !== want.status)      ||
              (result.child_count !== want.child_count);
        if (bad) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"[%0t] mismatch: found exp %h got %h, ",
                      "status exp %0d got %0d, count exp %0d got %0d"},
                     $time, want.found_child, result.found_child, want.status, result.status,
                     want.child_count, result.child_count);
        end
      end
    end
  end

  initial begin : stimulus
    int                     i;
    int                     roll;
    req_t                   r;
    logic [FIELD_PTR_W-1:0] ones;
    ones          = '1;
    rst           = 1'b1;
    start         = 1'b0;
    request       = '0;
    child_total   = 0;
    mismatches    = 0;
    results_seen  = 0;
    full_seen     = 0;
    absent_seen   = 0;
    requests_sent = 0;
    for (i = 0; i < KEY_SPACE; i++) key_slot[i] = EMPTY_MARK;
    for (i = 0; i < DEF_SLOTS; i++) slot_ptr[i] = '0;

    // Directed rows: empty node, extremes of key and child, zero child, duplicate key,
    // replace of absent and present keys, and the spare operation code.
    dir_rows.push_back(row(OP_LOOKUP,  8'h00, '0,   1, '0,   ST_ABSENT, 6'd0));
    dir_rows.push_back(row(OP_LOOKUP,  8'hFF, '0,   1, '0,   ST_ABSENT, 6'd0));
    dir_rows.push_back(row(OP_REPLACE, 8'h55, ones, 1, '0,   ST_ABSENT, 6'd0));
    dir_rows.push_back(row(OP_IGNORED, 8'hAA, ones, 1, '0,   ST_OK,     6'd0));
    dir_rows.push_back(row(OP_INSERT,  8'h00, ones, 1, '0,   ST_OK,     6'd1));
    dir_rows.push_back(row(OP_LOOKUP,  8'h00, '0,   1, ones, ST_OK,     6'd1));
    dir_rows.push_back(row(OP_INSERT,  8'hFF, 64'h1, 1, '0,  ST_OK,     6'd2));
    dir_rows.push_back(row(OP_LOOKUP,  8'hFF, '0,   1, 64'h1, ST_OK,    6'd2));
    // Zero child: stored and counted, found as a present key with a zero pointer.
    dir_rows.push_back(row(OP_INSERT,  8'h10, '0,   1, '0,   ST_OK,     6'd3));
    dir_rows.push_back(row(OP_LOOKUP,  8'h10, '0,   1, '0,   ST_OK,     6'd3));
    // The next insert reuses that zero slot, so key 10 now sees the new child.
    dir_rows.push_back(row(OP_INSERT,  8'h20, 64'hA5A5_5A5A_0F0F_F0F0, 0, '0, ST_OK, '0));
    dir_rows.push_back(row(OP_LOOKUP,  8'h10, '0,   0, '0, ST_OK, '0));
    dir_rows.push_back(row(OP_INSERT,  8'h00, 64'h8000_0000_0000_0001, 0, '0, ST_OK, '0));
    dir_rows.push_back(row(OP_LOOKUP,  8'h00, '0,   0, '0, ST_OK, '0));
    dir_rows.push_back(row(OP_REPLACE, 8'h00, '0,   0, '0, ST_OK, '0));
    dir_rows.push_back(row(OP_LOOKUP,  8'h00, '0,   0, '0, ST_OK, '0));
    dir_rows.push_back(row(OP_REPLACE, 8'hFF, ones, 0, '0, ST_OK, '0));
    dir_rows.push_back(row(OP_LOOKUP,  8'hFF, '0,   0, '0, ST_OK, '0));
    dir_rows.push_back(row(OP_IGNORED, 8'hFF, '0,   0, '0, ST_OK, '0));
    dir_rows.push_back(row(OP_LOOKUP,  8'h7F, ones, 0, '0, ST_OK, '0));

    // Hold reset, then release it for good.
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[k])
      issue(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].want, 1'b1);

    // Random part: inserts are sparse enough that the node fills part way through,
    // after which full rejections mix with lookups and replaces of live keys.
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      roll = $urandom_range(99);
      if      (roll < 45) r.operation = OP_LOOKUP;
      else if (roll < 60) r.operation = OP_INSERT;
      else if (roll < 95) r.operation = OP_REPLACE;
      else                r.operation = OP_IGNORED;
      if (known_keys.size() != 0 && $urandom_range(99) < 70)
        r.key_sel = known_keys[$urandom_range(known_keys.size() - 1)];
      else
        r.key_sel = KEY_W'($urandom_range(255));
      case ($urandom_range(9))
        0:       r.child_value = '0;
        1:       r.child_value = ones;
        default: r.child_value = {$urandom, $urandom};
      endcase
      issue(r, 1'b0, '0, !(i >= QUIET_FIRST && i < QUIET_LAST));
    end
    start <= 1'b0;

    // Drain: wait for every owed result, then watch for stray strobes.
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Sent %0d requests, checked %0d results (%0d full, %0d absent), %0d children held",
             requests_sent, results_seen, full_seen, absent_seen, child_total);
    $display("Mismatching or unexpected results: %0d", mismatches);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
